>>> sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> sv/swva_pkg.sv
package swva_pkg;

   localparam int HeadDim = 128;
   localparam int PosW = 7;
   localparam logic [24:0] SumMax = 25'd16777216;
   localparam logic [47:0] AccMax = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] AccMin = 48'h8000_0000_0000;
   localparam logic [16:0] Log2eQ16 = 17'd94548;

   typedef struct packed {
      logic signed [23:0] score;
      logic signed [23:0] max_logit;
      logic signed [15:0] value_element;
      logic signed [47:0] prior_element;
      logic first_key;
      logic last_key;
   } req_type;

   typedef struct packed {
      logic signed [47:0] element_value;
      logic [6:0] element_position;
      logic [24:0] weight_total;
      logic done_res;
      logic overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPMUL,
      ST_EXPINT,
      ST_EXPSHIFT,
      ST_READ,
      ST_MAC,
      ST_OUT
   } state_type;

   function automatic logic [16:0] pow2_tab(input logic [4:0] i);
      logic [16:0] t;
      case (i)
         5'd0: t = 17'd65536;
         5'd1: t = 17'd62757;
         5'd2: t = 17'd60097;
         5'd3: t = 17'd57549;
         5'd4: t = 17'd55109;
         5'd5: t = 17'd52773;
         5'd6: t = 17'd50535;
         5'd7: t = 17'd48393;
         5'd8: t = 17'd46341;
         5'd9: t = 17'd44376;
         5'd10: t = 17'd42495;
         5'd11: t = 17'd40693;
         5'd12: t = 17'd38968;
         5'd13: t = 17'd37316;
         5'd14: t = 17'd35734;
         5'd15: t = 17'd34219;
         default: t = 17'd32768;
      endcase
      return t;
   endfunction

endpackage

>>> sv/softmax_weighted_value_accumulate.sv
// Channel | Dir | Handshake        | Payload
// req     | in  | req_valid/stall  | req_type
// rsp     | out | rsp_valid/stall  | rsp_type
// csr     | in  | csr_valid/ready  | row_length[7:0]
// Element zero of a row first steps through exponent multiply, interpolate, shift
// (exponent uses the shared multiplier); every element then goes read, multiply-add, out.
// The next request is accepted as soon as the sequencer is back in idle.
// Synchronous active-high reset; accumulator memory is not cleared.
// A stalled result holds in the output register; the next request waits
// ahead of its multiply-add until that result is taken.
module softmax_weighted_value_accumulate import swva_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_data
);

   state_type state_ff, state_in;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] len_ff;
   logic [PosW-1:0] pos_ff, pos_in, cur_ff, cur_in;
   logic [16:0] weight_ff, weight_in;
   logic [24:0] sum_ff, sum_in;
   logic flag_ff, flag_in;
   logic [47:0] t_ff, t_in;
   logic signed [47:0] acc_rd_ff;
   logic signed [47:0] mem [HeadDim];
   logic mem_we;
   logic signed [47:0] mem_wd;

   // shared multiplier
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [7:0] len_eff;
   logic signed [24:0] diff;
   logic [15:0] f;
   logic [16:0] ti, ti1;
   logic [16:0] m;
   logic [47:0] kk;
   logic [17:0] mr;
   logic [16:0] wexp;
   logic [25:0] base;
   logic signed [49:0] accsum;
   logic signed [32:0] prod;
   logic signed [47:0] acc_sat;
   logic acc_of;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      if (len_ff == 8'd0) len_eff = 8'd1;
      else if (len_ff > 8'(HeadDim)) len_eff = 8'(HeadDim);
      else len_eff = len_ff;
   end

   assign diff = 25'(req_ff.score) - 25'(req_ff.max_logit);
   assign f = t_ff[15:0];
   assign ti = pow2_tab({1'b0, f[15:12]});
   assign ti1 = pow2_tab({1'b0, f[15:12]} + 5'd1);
   assign m = ti - 17'(mul_p[29:0] + 30'd2048 >> 12);
   assign kk = t_ff >> 16;
   assign mr = 18'(weight_ff) + ((kk == 48'd0) ? 18'd0 : 18'(18'd1 << (kk[4:0] - 5'd1)));
   assign wexp = (kk == 48'd0) ? weight_ff : (kk > 48'd17) ? 17'd0 : 17'(mr >> kk[4:0]);
   assign prod = $signed(mul_p[32:0]);
   assign accsum = 50'(acc_rd_ff) + 50'(prod);
   always_comb begin
      acc_of = 1'b0;
      acc_sat = accsum[47:0];
      if (accsum > 50'sh0_7FFF_FFFF_FFFF) begin
         acc_sat = AccMax; acc_of = 1'b1;
      end else if (accsum < -50'sh0_8000_0000_0000) begin
         acc_sat = AccMin; acc_of = 1'b1;
      end
   end
   assign base = (req_ff.first_key ? 26'd0 : 26'(sum_ff)) + 26'(wexp);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      weight_in = weight_ff;
      sum_in = sum_ff;
      flag_in = flag_ff;
      t_in = t_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we = 1'b0;
      mem_wd = acc_sat;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cur_in = (8'(pos_ff) >= len_eff) ? '0 : pos_ff;
               flag_in = 1'b0;
               state_in = (cur_in == '0) ? ST_EXPMUL : ST_READ;
            end
         end
         ST_EXPMUL: begin
            // y = round(max(-diff, 0) * log2e)
            mul_a = (diff > 0) ? 33'd0 : 33'(-diff);
            mul_b = 33'(Log2eQ16);
            flag_in = diff > 0;
            t_in = 48'((mul_p + 66'd32768) >> 16);
            state_in = ST_EXPINT;
         end
         ST_EXPINT: begin
            mul_a = 33'(ti - ti1);
            mul_b = 33'(f[11:0]);
            weight_in = m;
            state_in = ST_EXPSHIFT;
         end
         ST_EXPSHIFT: begin
            weight_in = wexp;
            if (base > 26'(SumMax)) begin
               sum_in = SumMax; flag_in = 1'b1;
            end else sum_in = base[24:0];
            state_in = ST_READ;
         end
         ST_READ: state_in = (rsp_valid_ff && rsp_stall) ? ST_READ : ST_MAC;
         ST_MAC: begin
            mul_a = 33'(weight_ff);
            mul_b = 33'(signed'(req_ff.value_element));
            mem_we = 1'b1;
            rsp_in.element_value = acc_sat;
            rsp_in.element_position = cur_ff;
            rsp_in.done_res = req_ff.last_key && (8'(cur_ff) + 8'd1 == len_eff);
            rsp_in.weight_total = rsp_in.done_res ? sum_ff : '0;
            rsp_in.overflow = flag_ff || acc_of;
            if (rsp_in.done_res) sum_in = '0;
            pos_in = (8'(cur_ff) + 8'd1 == len_eff) ? '0 : cur_ff + 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff <= 8'd128;
         pos_ff <= '0;
         weight_ff <= '0;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         weight_ff <= weight_in;
         sum_ff <= sum_in;
         if (csr_valid && csr_ready) len_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) req_ff <= req_data;
      cur_ff <= cur_in;
      flag_ff <= flag_in;
      t_ff <= t_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_READ)
         acc_rd_ff <= req_ff.first_key ? req_ff.prior_element : mem[cur_ff];
      if (mem_we) mem[cur_ff] <= mem_wd;
   end

endmodule

>>> sv/swva_checker.sv
`include "assert_macros.svh"
module swva_checker import swva_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input rsp_type rsp_data
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_NEXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall)
   `CHK_IMPLY(a_sum_zero, clock, reset, rsp_valid && !rsp_data.done_res, rsp_data.weight_total == 25'd0)
   `CHK_NEXT(a_rsp_gap, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
endmodule

bind softmax_weighted_value_accumulate swva_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

>>> tb/sv/softmax_weighted_value_accumulate_tb.sv
module softmax_weighted_value_accumulate_tb;
   import swva_pkg::*;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   localparam longint AccHi = 64'sd140737488355327;
   localparam longint AccLo = -64'sd140737488355328;
   localparam int WatchLimit = 4000;
   localparam int LongHold = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_data = 8'd0;

   softmax_weighted_value_accumulate u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   longint     acc_mem [HeadDim];
   logic [16:0] cur_weight = '0;
   logic [24:0] run_sum = '0;
   int         pos_cnt = 0;
   logic [7:0] row_len = 8'd128;

   // generator shadow of position and written elements
   int gen_pos = 0;
   int gen_len = HeadDim;
   bit gen_written [HeadDim];

   stim_row_type request_queue[$];
   rsp_type      expected_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   int cycle_cnt = 0;
   int hold_cnt = 0;
   bit long_done = 0;

   function automatic int eff_len(logic [7:0] v);
      if (v == 0) return 1;
      if (v > HeadDim) return HeadDim;
      return v;
   endfunction

   function automatic logic [16:0] exp_weight(longint mag);
      int     tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
                          44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      longint y;
      longint k;
      int     f;
      int     i;
      int     r;
      int     m;
      y = (mag * 94548 + 32768) >>> 16;
      k = y >>> 16;
      f = int'(y & 65535);
      i = f >> 12;
      r = f & 4095;
      m = tab[i] - (((tab[i] - tab[i + 1]) * r + 2048) >> 12);
      if (k == 0) return 17'(m);
      if (k > 17) return 17'd0;
      return 17'((m + (1 << (k - 1))) >> k);
   endfunction

   function automatic rsp_type accumulate_step(req_type q);
      rsp_type res;
      int      len;
      int      p;
      bit      flag;
      bit      done;
      longint  diff;
      longint  base;
      longint  a;
      flag = 0;
      len = eff_len(row_len);
      if (pos_cnt >= len) pos_cnt = 0;
      p = pos_cnt;
      if (p == 0) begin
         diff = longint'(q.score) - longint'(q.max_logit);
         if (diff > 0) begin
            diff = 0;
            flag = 1;
         end
         cur_weight = exp_weight(-diff);
         base = q.first_key ? 0 : longint'(run_sum);
         base += longint'(cur_weight);
         if (base > longint'(SumMax)) begin
            base = SumMax;
            flag = 1;
         end
         run_sum = base[24:0];
      end
      a = q.first_key ? longint'(q.prior_element) : acc_mem[p];
      a += longint'(cur_weight) * longint'(q.value_element);
      if (a > AccHi) begin
         a = AccHi;
         flag = 1;
      end else if (a < AccLo) begin
         a = AccLo;
         flag = 1;
      end
      acc_mem[p] = a;
      done = q.last_key && (p + 1 == len);
      res.element_value = a[47:0];
      res.element_position = p[6:0];
      res.weight_total = done ? run_sum : '0;
      res.done_res = done;
      res.overflow = flag;
      if (done) run_sum = '0;
      pos_cnt = (p + 1 == len) ? 0 : p + 1;
      return res;
   endfunction

   function automatic void queue_request(req_type q, bit known, rsp_type e);
      stim_row_type row;
      if (gen_pos >= gen_len) gen_pos = 0;
      if (!q.first_key && !gen_written[gen_pos]) q.first_key = 1'b1;
      gen_written[gen_pos] = 1;
      gen_pos = (gen_pos + 1 == gen_len) ? 0 : gen_pos + 1;
      row.req = q;
      row.known = known;
      row.rsp = e;
      request_queue.push_back(row);
   endfunction

   function automatic req_type rand_request(bit first, bit last, bit zero_diff);
      req_type q;
      int      mx;
      q.value_element = 16'($urandom);
      q.prior_element = 48'({$urandom, $urandom});
      case ($urandom_range(0, 9))
         0: q.prior_element = AccMax - $urandom_range(0, 1000);
         1: q.prior_element = AccMin + $urandom_range(0, 1000);
         default: ;
      endcase
      mx = int'($urandom_range(0, 8388607)) - 4194304;
      q.max_logit = 24'(mx);
      case ($urandom_range(0, 9))
         0: begin
            q.score = 24'($urandom);
            q.max_logit = 24'($urandom);
         end
         1: q.score = 24'(mx + int'($urandom_range(0, 100000)));
         2, 3: q.score = 24'(mx - int'($urandom_range(0, 1048575)));
         default: q.score = 24'(mx - int'($urandom_range(0, 131071)));
      endcase
      if (zero_diff) q.score = q.max_logit;
      q.first_key = first;
      q.last_key = last;
      return q;
   endfunction

   task automatic gen_block(int nkeys, bit zero_diff);
      for (int k = 0; k < nkeys; k++)
         for (int e = 0; e < gen_len; e++)
            queue_request(rand_request(k == 0, k == nkeys - 1, zero_diff), 0, '0);
   endtask

   task automatic write_row_length(logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      row_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
      gen_len = eff_len(v);
   endtask

   task automatic send_requests();
      stim_row_type row;
      int burst = 0;
      int gap;
      @(negedge clock);
      while (request_queue.size() > 0) begin
         row = request_queue.pop_front();
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst--;
         req_valid <= 1'b1;
         req_data <= row.req;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         if (row.known) begin
            void'(accumulate_step(row.req));
            expected_rsp.push_back(row.rsp);
         end else begin
            expected_rsp.push_back(accumulate_step(row.req));
         end
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic directed_row(req_type q, bit known, rsp_type e);
      queue_request(q, known, e);
   endtask

   // receiver stall pattern, with one long hold
   always @(negedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (!long_done && cycle_cnt > 3000 && req_valid) begin
         long_done <= 1;
         hold_cnt <= LongHold;
         rsp_stall <= 1'b1;
      end else if ((cycle_cnt / 500) % 3 == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready) || hold_cnt > 0)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("softmax_weighted_value_accumulate test failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.element_value !== e.element_value ||
                   rsp_data.element_position !== e.element_position ||
                   rsp_data.weight_total !== e.weight_total ||
                   rsp_data.done_res !== e.done_res ||
                   rsp_data.overflow !== e.overflow) begin
                  errors++;
                  if (errors <= 10) $display("mismatch exp %p act %p", e, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      int lens [12] = '{1, 0, 2, 128, 5, 255, 200, 3, 17, 1, 64, 8};
      int count;
      for (int i = 0; i < HeadDim; i++) begin
         acc_mem[i] = 0;
         gen_written[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_row_length(8'd1);
      directed_row(req_type'{24'sd0, 24'sd0, 16'sd0, 48'sd0, 1'b1, 1'b1}, 1,
                   rsp_type'{48'sd0, 7'd0, 25'd65536, 1'b1, 1'b0});
      directed_row(req_type'{24'sd8388607, -24'sd8388608, 16'sd0, 48'sd5, 1'b1, 1'b1}, 1,
                   rsp_type'{48'sd5, 7'd0, 25'd65536, 1'b1, 1'b1});
      directed_row(req_type'{-24'sd8388608, 24'sd8388607, 16'sd32767, -48'sd1, 1'b1, 1'b1},
                   1, rsp_type'{-48'sd1, 7'd0, 25'd0, 1'b1, 1'b0});
      directed_row(req_type'{24'sd0, 24'sd0, 16'sd32767, AccMax, 1'b1, 1'b1}, 1,
                   rsp_type'{AccMax, 7'd0, 25'd65536, 1'b1, 1'b1});
      directed_row(req_type'{24'sd0, 24'sd0, -16'sd32768, AccMin, 1'b1, 1'b1}, 1,
                   rsp_type'{AccMin, 7'd0, 25'd65536, 1'b1, 1'b1});
      directed_row(req_type'{24'sd0, 24'sd0, 16'sd100, 48'sd0, 1'b1, 1'b0}, 1,
                   rsp_type'{48'sd6553600, 7'd0, 25'd0, 1'b0, 1'b0});
      directed_row(req_type'{24'sd0, -24'sd65536, -16'sd100, 48'sd0, 1'b0, 1'b0}, 0, '0);
      directed_row(req_type'{-24'sd1, 24'sd0, 16'sd4096, 48'sd0, 1'b0, 1'b0}, 0, '0);
      directed_row(req_type'{-24'sd300000, 24'sd0, -16'sd4096, 48'sd0, 1'b0, 1'b1}, 0, '0);
      directed_row(req_type'{24'sd1000, 24'sd2000, 16'sd1, 48'sd77, 1'b0, 1'b1}, 0, '0);
      send_requests();
      drain();

      // several elements per row, including mid-row register change
      write_row_length(8'd3);
      gen_block(2, 0);
      queue_request(rand_request(0, 0, 0), 0, '0);
      send_requests();
      drain();

      foreach (lens[ph]) begin
         write_row_length(lens[ph][7:0]);
         count = 0;
         if (gen_len == 1 && ph == 0) begin
            gen_block(260, 1);
            count = 260;
         end
         while (count < 100) begin
            if ($urandom_range(0, 9) < 8) begin
               gen_block(gen_len >= 64 ? 1 : $urandom_range(1, 4), $urandom_range(0, 15) == 0);
               count += gen_len;
            end else begin
               for (int n = $urandom_range(1, 3); n > 0; n--) begin
                  queue_request(rand_request($urandom, $urandom, 0), 0, '0);
                  count++;
               end
            end
         end
         send_requests();
         drain();
      end

      repeat (20) @(posedge clock);
      if (expected_rsp.size() > 0) errors++;
      if (errors == 0) begin
         $display("softmax_weighted_value_accumulate test passed");
      end else begin
         $display("softmax_weighted_value_accumulate test failed");
      end
      $finish;
   end

endmodule
